>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, reset-gated on an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SPID_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SPID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spid_pkg.sv
// ---------------------------------------------------------------------------
// spid_pkg
// Widths, register indexes, reset values and shared types of the servo
// position PID loop.
// ---------------------------------------------------------------------------
package spid_pkg;

    localparam int POSITION_BITS_DEF = 12;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_TORQUE_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GOAL_POSITION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_PERIOD   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_RATE     = 3'd6;

    localparam int GOAL_CFG_W = 12;
    localparam int GAIN_W     = 16;
    localparam int PERIOD_W   = 24;
    localparam int RATE_W     = 16;
    localparam int ACC_W      = 48;
    localparam int HALF_W     = 24;
    localparam int DRIVE_W    = 16;
    localparam int TOTAL_W    = 56;
    localparam int MUL_B_W    = PERIOD_W + 1;

    // Term alignment: everything is summed in 1/256 of a drive LSB
    localparam int P_SHIFT_BASE = 16;
    localparam int D_SHIFT_BASE = 19;
    localparam int I_SHIFT_BASE = 17;
    localparam int OUT_SHIFT    = 8;
    // Integral clamp bound is 2^(BOUND_BASE + position bits) / gain_i
    localparam int BOUND_BASE   = 40;

    localparam int DRIVE_LIMIT = 32767;

    localparam logic [GOAL_CFG_W-1:0] GOAL_RESET   = 12'd2048;
    localparam logic [GAIN_W-1:0]     GAIN_P_RESET = 16'd850;
    localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 24'd16777;
    localparam logic [RATE_W-1:0]     RATE_RESET   = 16'd1000;

    typedef struct packed {
        logic                torque_enable;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [PERIOD_W-1:0] tick_period;
        logic [RATE_W-1:0]   tick_rate;
    } spid_cfg_t;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] divisor;
    } spid_div_req_t;

endpackage

>>> rtl/spid_div.sv
// ---------------------------------------------------------------------------
// spid_div
// Bit-serial restoring divider forming the integral clamp bound
// 2^(40+P) / gain_i, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module spid_div #(
    parameter int POSITION_BITS = spid_pkg::POSITION_BITS_DEF
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  spid_pkg::spid_div_req_t                               req,
    output logic                                                  busy,
    output logic [spid_pkg::BOUND_BASE + POSITION_BITS:0]         bound
);

    localparam int K    = spid_pkg::BOUND_BASE + POSITION_BITS;
    localparam int QW   = K + 1;
    localparam int CNTW = $clog2(K + 1);
    localparam int GW   = spid_pkg::GAIN_W;

    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [GW-1:0]   rem_reg;
    logic [GW-1:0]   div_reg;
    logic [QW-1:0]   quo_reg;

    logic            dbit;
    logic [GW:0]     trial;
    logic [GW:0]     diff;
    logic            fits;
    logic [GW-1:0]   rem_next;

    // The dividend is a single one at bit K
    assign dbit     = (cnt_reg == CNTW'(K));
    assign trial    = {rem_reg, dbit};
    assign fits     = (trial >= {1'b0, div_reg});
    assign diff     = trial - {1'b0, div_reg};
    assign rem_next = fits ? diff[GW-1:0] : trial[GW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(K);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign busy  = busy_reg;
    assign bound = quo_reg;

endmodule

>>> rtl/spid_mul.sv
// ---------------------------------------------------------------------------
// spid_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module spid_mul #(
    parameter int A_W = spid_pkg::POSITION_BITS_DEF + 19,
    parameter int B_W = spid_pkg::MUL_B_W
) (
    input  logic                        clk,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic signed [A_W+B_W-1:0]   p
);

    logic signed [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign p = prod_reg;

endmodule

>>> rtl/spid_core.sv
// ---------------------------------------------------------------------------
// spid_core
// Sequencer and datapath of the PID tick: schedules the shared multiplier,
// accumulates and clamps the integral, sums and saturates the drive word.
// ---------------------------------------------------------------------------
module spid_core #(
    parameter int POSITION_BITS = spid_pkg::POSITION_BITS_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  spid_pkg::spid_cfg_t                                cfg,
    input  logic [POSITION_BITS-1:0]                           goal,
    input  logic [spid_pkg::BOUND_BASE + POSITION_BITS:0]      bound,
    input  logic                                               div_busy,
    input  logic                                               measure_valid,
    output logic                                               measure_stall,
    input  logic [POSITION_BITS-1:0]                           measured_position,
    output logic                                               drive_valid,
    input  logic                                               drive_stall,
    output logic signed [spid_pkg::DRIVE_W-1:0]                drive
);

    localparam int P       = POSITION_BITS;
    localparam int EW      = P + 1;
    localparam int DW      = P + 2;
    localparam int MAW     = P + spid_pkg::GAIN_W + 3;
    localparam int MBW     = spid_pkg::MUL_B_W;
    localparam int MPW     = MAW + MBW;
    localparam int QW      = spid_pkg::BOUND_BASE + P + 1;
    localparam int AW      = spid_pkg::ACC_W;
    localparam int SW      = AW + 1;
    localparam int CW      = (QW + 1 > AW) ? QW + 1 : AW;
    localparam int IPW     = spid_pkg::GAIN_W + AW + 2;
    localparam int TW      = spid_pkg::TOTAL_W;
    localparam int HW      = spid_pkg::HALF_W;
    localparam int OW      = spid_pkg::DRIVE_W;
    localparam int P_SHIFT = spid_pkg::P_SHIFT_BASE - P;
    localparam int D_SHIFT = spid_pkg::D_SHIFT_BASE - P;
    localparam int I_SHIFT = spid_pkg::I_SHIFT_BASE + P;

    localparam logic signed [TW-1:0] DMAX_T  = TW'(spid_pkg::DRIVE_LIMIT);
    localparam logic signed [TW-1:0] DMIN_T  = TW'(-spid_pkg::DRIVE_LIMIT);
    localparam logic signed [OW-1:0] DMAX_O  = OW'(spid_pkg::DRIVE_LIMIT);
    localparam logic signed [OW-1:0] DMIN_O  = OW'(-spid_pkg::DRIVE_LIMIT);
    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_PER   = 11'b00000000010,
        ST_P     = 11'b00000000100,
        ST_D1    = 11'b00000001000,
        ST_D2    = 11'b00000010000,
        ST_IL    = 11'b00000100000,
        ST_IH    = 11'b00001000000,
        ST_ICOMB = 11'b00010000000,
        ST_IADD  = 11'b00100000000,
        ST_FIN   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } spid_state_t;

    spid_state_t state_reg;
    spid_state_t state_next;

    logic signed [EW-1:0]  err_reg;
    logic signed [DW-1:0]  derr_reg;
    logic signed [EW-1:0]  prev_err_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [AW-1:0]  acc_work_reg;
    logic signed [TW-1:0]  total_reg;
    logic signed [IPW-1:0] ilo_reg;
    logic signed [IPW-1:0] iprod_reg;
    logic signed [OW-1:0]  drive_res_reg;
    logic signed [OW-1:0]  drive_reg;
    logic                  drive_valid_reg;

    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [MPW-1:0] prod;

    logic                  accept;
    logic                  out_free;
    logic                  load;
    logic signed [EW-1:0]  err_new;
    logic signed [DW-1:0]  derr_new;
    logic signed [SW-1:0]  acc_sum;
    logic signed [AW-1:0]  acc_sat;
    logic signed [CW-1:0]  acc_x;
    logic signed [CW-1:0]  bnd_x;
    logic signed [AW-1:0]  acc_clamp;
    logic signed [TW-1:0]  pterm;
    logic signed [TW-1:0]  dterm_add;
    logic signed [IPW-1:0] iprod_new;
    logic signed [TW-1:0]  iterm;
    logic signed [TW-1:0]  total_i;
    logic signed [TW-1:0]  t8;
    logic signed [OW-1:0]  drive_sat;
    logic                  gain_i_on;

    spid_mul #(
        .A_W (MAW),
        .B_W (MBW)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign measure_stall = (state_reg != ST_IDLE) || div_busy;
    assign accept        = measure_valid && !measure_stall;
    assign out_free      = !drive_valid_reg || !drive_stall;
    assign load          = (state_reg == ST_OUT) && out_free;
    assign gain_i_on     = (cfg.gain_i != '0);

    assign err_new  = $signed({1'b0, goal}) - $signed({1'b0, measured_position});
    assign derr_new = DW'(err_new) - DW'(prev_err_reg);

    // Integral sum, saturated to the accumulator range
    assign acc_sum = SW'(acc_reg) + SW'(prod);

    always_comb
    begin
        if (acc_sum[SW-1] != acc_sum[SW-2])
        begin
            acc_sat = acc_sum[SW-1] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_sat = acc_sum[AW-1:0];
        end
    end

    // Clamp so that gain_i times the integral stays within full scale
    assign acc_x = CW'(acc_work_reg);
    assign bnd_x = $signed(CW'(bound));

    always_comb
    begin
        acc_clamp = acc_work_reg;
        if (gain_i_on)
        begin
            if (acc_x > bnd_x)
            begin
                acc_clamp = AW'(bnd_x);
            end
            else if (acc_x < -bnd_x)
            begin
                acc_clamp = AW'(-bnd_x);
            end
        end
    end

    assign pterm     = TW'(prod) <<< P_SHIFT;
    assign dterm_add = total_reg + (TW'(prod) <<< D_SHIFT);
    assign iprod_new = (IPW'(prod) <<< HW) + ilo_reg;
    assign iterm     = TW'(iprod_reg >>> I_SHIFT);
    assign total_i   = gain_i_on ? (total_reg + iterm) : total_reg;
    assign t8        = total_reg >>> spid_pkg::OUT_SHIFT;

    always_comb
    begin
        if (t8 > DMAX_T)
        begin
            drive_sat = DMAX_O;
        end
        else if (t8 < DMIN_T)
        begin
            drive_sat = DMIN_O;
        end
        else
        begin
            drive_sat = t8[OW-1:0];
        end
    end

    // Operand selection for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_PER:
            begin
                mul_a = MAW'(err_reg);
                mul_b = $signed({1'b0, cfg.tick_period});
            end
            ST_P:
            begin
                mul_a = MAW'(err_reg);
                mul_b = $signed(MBW'({1'b0, cfg.gain_p}));
            end
            ST_D1:
            begin
                mul_a = MAW'(derr_reg);
                mul_b = $signed(MBW'({1'b0, cfg.gain_d}));
            end
            ST_D2:
            begin
                mul_a = MAW'(prod);
                mul_b = $signed(MBW'({1'b0, cfg.tick_rate}));
            end
            ST_IL:
            begin
                mul_a = $signed(MAW'({1'b0, cfg.gain_i}));
                mul_b = $signed({1'b0, acc_work_reg[HW-1:0]});
            end
            ST_IH:
            begin
                mul_a = $signed(MAW'({1'b0, cfg.gain_i}));
                mul_b = MBW'($signed(acc_work_reg[AW-1:HW]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cfg.torque_enable ? ST_PER : ST_OUT;
                end
            end
            ST_PER:   state_next = ST_P;
            ST_P:     state_next = ST_D1;
            ST_D1:    state_next = ST_D2;
            ST_D2:    state_next = ST_IL;
            ST_IL:    state_next = ST_IH;
            ST_IH:    state_next = ST_ICOMB;
            ST_ICOMB: state_next = ST_IADD;
            ST_IADD:  state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prev_err_reg    <= '0;
            acc_reg         <= '0;
            drive_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Commit loop state only at the end of an enabled tick
            if (state_reg == ST_FIN)
            begin
                prev_err_reg <= err_reg;
                acc_reg      <= acc_work_reg;
            end
            if (load)
            begin
                drive_valid_reg <= 1'b1;
            end
            else if (!drive_stall)
            begin
                drive_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg       <= err_new;
            derr_reg      <= derr_new;
            drive_res_reg <= '0;
        end
        case (state_reg)
            ST_P:     acc_work_reg  <= acc_sat;
            ST_D1:
            begin
                total_reg    <= pterm;
                acc_work_reg <= acc_clamp;
            end
            ST_IL:    total_reg     <= dterm_add;
            ST_IH:    ilo_reg       <= IPW'(prod);
            ST_ICOMB: iprod_reg     <= iprod_new;
            ST_IADD:  total_reg     <= total_i;
            ST_FIN:   drive_res_reg <= drive_sat;
            default:  ;
        endcase
        if (load)
        begin
            drive_reg <= drive_res_reg;
        end
    end

    assign drive_valid = drive_valid_reg;
    assign drive       = drive_reg;

endmodule

>>> rtl/servo_position_pid.sv
// ---------------------------------------------------------------------------
// servo_position_pid
// Position PID loop of a brushed servo: one measured position in, one
// saturated Q1.15 drive word out per control tick.
//
//   channel    handshake                      payload
//   measure    measure_valid / measure_stall  measured_position
//   drive      drive_valid / drive_stall      drive
//   config     cfg_write                      cfg_index, cfg_data
//
// An enabled tick steps through ST_PER, ST_P, ST_D1, ST_D2, ST_IL, ST_IH, ST_ICOMB,
// ST_IADD and ST_FIN, sharing the one multiplier, then loads the drive word in ST_OUT
// once the output is free; a disabled tick goes from accept straight to ST_OUT.
// A new word is taken once the previous result sits in the output register.
// A gain_i write runs the clamp-bound divider, during which measure_stall is held.
// Reset loads the register defaults and zeroes error and integral state.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module servo_position_pid #(
    parameter int POSITION_BITS = spid_pkg::POSITION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [spid_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [spid_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  measure_valid,
    output logic                                  measure_stall,
    input  logic [POSITION_BITS-1:0]              measured_position,
    output logic                                  drive_valid,
    input  logic                                  drive_stall,
    output logic signed [spid_pkg::DRIVE_W-1:0]   drive
);

    localparam int QW = spid_pkg::BOUND_BASE + POSITION_BITS + 1;
    localparam int GW = spid_pkg::GAIN_W;

    logic                             torque_enable_reg;
    logic [POSITION_BITS-1:0]         goal_position_reg;
    logic [GW-1:0]                    gain_p_reg;
    logic [GW-1:0]                    gain_i_reg;
    logic [GW-1:0]                    gain_d_reg;
    logic [spid_pkg::PERIOD_W-1:0]    tick_period_reg;
    logic [spid_pkg::RATE_W-1:0]      tick_rate_reg;

    spid_pkg::spid_cfg_t              cfg;
    spid_pkg::spid_div_req_t          div_req;
    logic                             div_busy;
    logic [QW-1:0]                    bound;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            torque_enable_reg <= 1'b0;
            goal_position_reg <= POSITION_BITS'(spid_pkg::GOAL_RESET);
            gain_p_reg        <= spid_pkg::GAIN_P_RESET;
            gain_i_reg        <= '0;
            gain_d_reg        <= '0;
            tick_period_reg   <= spid_pkg::PERIOD_RESET;
            tick_rate_reg     <= spid_pkg::RATE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                spid_pkg::CFG_TORQUE_ENABLE: torque_enable_reg <= cfg_data[0];
                spid_pkg::CFG_GOAL_POSITION:
                    goal_position_reg <= POSITION_BITS'(cfg_data[spid_pkg::GOAL_CFG_W-1:0]);
                spid_pkg::CFG_GAIN_P:        gain_p_reg      <= cfg_data[GW-1:0];
                spid_pkg::CFG_GAIN_I:        gain_i_reg      <= cfg_data[GW-1:0];
                spid_pkg::CFG_GAIN_D:        gain_d_reg      <= cfg_data[GW-1:0];
                spid_pkg::CFG_TICK_PERIOD:   tick_period_reg <= cfg_data;
                spid_pkg::CFG_TICK_RATE:
                    tick_rate_reg <= cfg_data[spid_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.torque_enable = torque_enable_reg;
    assign cfg.gain_p        = gain_p_reg;
    assign cfg.gain_i        = gain_i_reg;
    assign cfg.gain_d        = gain_d_reg;
    assign cfg.tick_period   = tick_period_reg;
    assign cfg.tick_rate     = tick_rate_reg;

    // Recompute the clamp bound on every gain_i write
    assign div_req.start   = cfg_write && (cfg_index == spid_pkg::CFG_GAIN_I);
    assign div_req.divisor = cfg_data[GW-1:0];

    spid_div #(
        .POSITION_BITS (POSITION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .bound (bound)
    );

    spid_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .goal              (goal_position_reg),
        .bound             (bound),
        .div_busy          (div_busy),
        .measure_valid     (measure_valid),
        .measure_stall     (measure_stall),
        .measured_position (measured_position),
        .drive_valid       (drive_valid),
        .drive_stall       (drive_stall),
        .drive             (drive)
    );

    `SPID_ASSERT_NEXT(a_gain_i_starts_div, clk, rst_n, div_req.start, div_busy,
                      "gain_i write did not start the divider")
    `SPID_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, measure_valid && !measure_stall,
                      measure_stall, "input taken again straight after a word")
    `SPID_ASSERT_IMPL(a_drive_symmetric, clk, rst_n, drive_valid,
                      drive != {1'b1, {(spid_pkg::DRIVE_W-1){1'b0}}},
                      "drive outside symmetric range")

endmodule

>>> tb/servo_position_pid_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// servo_position_pid_tb
// Self-checking bench for the servo position PID loop. A scoreboard keeps its
// own copy of the registers, error and integral state and predicts each drive
// word from every position word taken. Directed ticks come first: torque off,
// field and register extremes and the integral clamp. Random segments with fresh
// settings follow under three handshake pressure phases; the last, with no
// pressure, opens with a long integral build-up run.
// ---------------------------------------------------------------------------
module servo_position_pid_tb;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_WORDS    = 400;
    localparam int SATURATE_WORDS = 300;
    localparam int REPORT_LIMIT   = 10;
    localparam int POS_W          = spid_pkg::POSITION_BITS_DEF;

    localparam int CFG_INDEX_W = spid_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = spid_pkg::CFG_DATA_W;
    localparam int GOAL_CFG_W  = spid_pkg::GOAL_CFG_W;
    localparam int GAIN_W      = spid_pkg::GAIN_W;
    localparam int PERIOD_W    = spid_pkg::PERIOD_W;
    localparam int RATE_W      = spid_pkg::RATE_W;
    localparam int DRIVE_W     = spid_pkg::DRIVE_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 3'd7;

    class servo_drive_scoreboard;
        bit                  torque_on;
        bit [GOAL_CFG_W-1:0] goal;
        bit [GAIN_W-1:0]     kp;
        bit [GAIN_W-1:0]     ki;
        bit [GAIN_W-1:0]     kd;
        bit [PERIOD_W-1:0]   period;
        bit [RATE_W-1:0]     rate;
        longint              last_error;
        longint              integral;
        logic signed [DRIVE_W-1:0] expected_drive_q[$];
        int                  failures;
        int                  reports;

        function new();
            torque_on  = 1'b0;
            goal       = spid_pkg::GOAL_RESET;
            kp         = spid_pkg::GAIN_P_RESET;
            ki         = '0;
            kd         = '0;
            period     = spid_pkg::PERIOD_RESET;
            rate       = spid_pkg::RATE_RESET;
            last_error = 0;
            integral   = 0;
            failures   = 0;
            reports    = 0;
        endfunction

        function void apply_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                spid_pkg::CFG_TORQUE_ENABLE: torque_on = data[0];
                spid_pkg::CFG_GOAL_POSITION: goal      = data[GOAL_CFG_W-1:0];
                spid_pkg::CFG_GAIN_P:        kp        = data[GAIN_W-1:0];
                spid_pkg::CFG_GAIN_I:        ki        = data[GAIN_W-1:0];
                spid_pkg::CFG_GAIN_D:        kd        = data[GAIN_W-1:0];
                spid_pkg::CFG_TICK_PERIOD:   period    = data[PERIOD_W-1:0];
                spid_pkg::CFG_TICK_RATE:     rate      = data[RATE_W-1:0];
                default:                     ;
            endcase
        endfunction

        function logic signed [DRIVE_W-1:0] predict_drive(logic [POS_W-1:0] pos);
            longint acc_top;
            longint err;
            longint delta;
            longint acc;
            longint bound;
            longint total;
            longint level;
            acc_top = (longint'(1) <<< (spid_pkg::ACC_W - 1)) - 1;
            // torque off: zero drive, state held
            if (!torque_on)
                return '0;
            err        = longint'(goal) - longint'(pos);
            delta      = err - last_error;
            last_error = err;
            acc = integral + err * longint'(period);
            if (acc > acc_top)
                acc = acc_top;
            if (acc < -acc_top - 1)
                acc = -acc_top - 1;
            if (ki != 0)
            begin
                bound = longint'(64'd1 << (spid_pkg::BOUND_BASE + POS_W)) / longint'(ki);
                if (acc > bound)
                    acc = bound;
                else if (acc < -bound)
                    acc = -bound;
            end
            integral = acc;
            // all terms in 1/256 of a drive step
            total = ((longint'(kp) * err) <<< (spid_pkg::P_SHIFT_BASE - POS_W))
                  + ((longint'(kd) * delta * longint'(rate))
                     <<< (spid_pkg::D_SHIFT_BASE - POS_W));
            if (ki != 0)
                total = total + ((longint'(ki) * acc) >>> (spid_pkg::I_SHIFT_BASE + POS_W));
            level = total >>> spid_pkg::OUT_SHIFT;
            if (level > spid_pkg::DRIVE_LIMIT)
                level = spid_pkg::DRIVE_LIMIT;
            if (level < -spid_pkg::DRIVE_LIMIT)
                level = -spid_pkg::DRIVE_LIMIT;
            return DRIVE_W'(level);
        endfunction

        function void note_position(logic [POS_W-1:0] pos);
            expected_drive_q.push_back(predict_drive(pos));
        endfunction

        function void check_drive(logic signed [DRIVE_W-1:0] seen);
            logic signed [DRIVE_W-1:0] want;
            if (expected_drive_q.size() == 0)
            begin
                failures++;
                if (reports < REPORT_LIMIT)
                    $display("[%0t] drive word %0d arrived with nothing outstanding",
                             $realtime, seen);
                reports++;
            end
            else
            begin
                want = expected_drive_q.pop_front();
                if (seen !== want)
                begin
                    failures++;
                    if (reports < REPORT_LIMIT)
                        $display("[%0t] drive mismatch: expected %0d, got %0d",
                                 $realtime, want, seen);
                    reports++;
                end
            end
        endfunction

        function int pending();
            return expected_drive_q.size();
        endfunction

        function int total_failures();
            return failures + expected_drive_q.size();
        endfunction
    endclass

    logic                        clk               = 1'b0;
    logic                        rst_n             = 1'b0;
    logic                        cfg_write         = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index         = '0;
    logic [CFG_DATA_W-1:0]       cfg_data          = '0;
    logic                        measure_valid     = 1'b0;
    logic                        measure_stall;
    logic [POS_W-1:0]            measured_position = '0;
    logic                        drive_valid;
    logic                        drive_stall       = 1'b0;
    logic signed [DRIVE_W-1:0]   drive;

    servo_drive_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int base_send_pct;
    int base_recv_pct;
    int idle_cycles;
    int words_taken;
    int drives_taken;
    int reg_writes;

    servo_position_pid u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .measure_valid     (measure_valid),
        .measure_stall     (measure_stall),
        .measured_position (measured_position),
        .drive_valid       (drive_valid),
        .drive_stall       (drive_stall),
        .drive             (drive)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    always @(negedge clk)
    begin
        drive_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (drive_valid && !drive_stall)
            begin
                sb.check_drive(drive);
                drives_taken++;
            end
            if (cfg_write)
            begin
                sb.apply_write(cfg_index, cfg_data);
                reg_writes++;
            end
            if (measure_valid && !measure_stall)
            begin
                sb.note_position(measured_position);
                words_taken++;
            end
            if ((drive_valid && !drive_stall) || cfg_write || (measure_valid && !measure_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("[%0t] watchdog: no traffic for %0d cycles", $realtime, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [GAIN_W-1:0] pick_gain(input int small_max);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return GAIN_W'($urandom_range(0, 65535));
            default: return GAIN_W'($urandom_range(0, small_max));
        endcase
    endfunction

    // Bits above the register width are filled at random; the block drops them
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int width);
        logic [CFG_DATA_W-1:0] mask;
        mask      = (24'd1 << width) - 24'd1;
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = (CFG_DATA_W'($urandom) & ~mask) | (value & mask);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic send_word(input logic [POS_W-1:0] pos);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            measure_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        measure_valid     = 1'b1;
        measured_position = pos;
        do
            @(posedge clk);
        while (measure_stall);
        @(negedge clk);
    endtask

    // Hold the sender until every drive word is back, then let the pipe drain
    task automatic settle();
        measure_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_directed();
        // torque off after reset
        send_word('0);
        send_word('1);
        settle();
        write_reg(spid_pkg::CFG_TORQUE_ENABLE, 1, 1);
        write_reg(CFG_UNMAPPED, 0, 0);
        send_word('0);
        send_word('1);
        send_word(12'd2048);
        send_word(12'd2047);
        // derivative at full gain and rate, integral frozen by a zero period
        settle();
        write_reg(spid_pkg::CFG_GOAL_POSITION, 0, GOAL_CFG_W);
        write_reg(spid_pkg::CFG_GAIN_P, 0, GAIN_W);
        write_reg(spid_pkg::CFG_GAIN_D, 16'hFFFF, GAIN_W);
        write_reg(spid_pkg::CFG_TICK_RATE, 16'hFFFF, RATE_W);
        write_reg(spid_pkg::CFG_TICK_PERIOD, 0, PERIOD_W);
        send_word('1);
        send_word('0);
        send_word('1);
        // zero rate kills the derivative term
        settle();
        write_reg(spid_pkg::CFG_TICK_RATE, 0, RATE_W);
        write_reg(spid_pkg::CFG_GAIN_P, 1, GAIN_W);
        send_word('0);
        send_word('1);
        // integral clamp, both signs
        settle();
        write_reg(spid_pkg::CFG_GAIN_D, 0, GAIN_W);
        write_reg(spid_pkg::CFG_TICK_RATE, 1, RATE_W);
        write_reg(spid_pkg::CFG_GAIN_P, 0, GAIN_W);
        write_reg(spid_pkg::CFG_TICK_PERIOD, 24'hFFFFFF, PERIOD_W);
        write_reg(spid_pkg::CFG_GOAL_POSITION, 12'hFFF, GOAL_CFG_W);
        write_reg(spid_pkg::CFG_GAIN_I, 16'hFFFF, GAIN_W);
        repeat (3) send_word('0);
        settle();
        write_reg(spid_pkg::CFG_GOAL_POSITION, 0, GOAL_CFG_W);
        repeat (3) send_word('1);
        // state must survive a spell with torque off
        settle();
        write_reg(spid_pkg::CFG_TORQUE_ENABLE, 0, 1);
        send_word(12'd1234);
        send_word('0);
        settle();
        write_reg(spid_pkg::CFG_TORQUE_ENABLE, 1, 1);
        send_word(12'd100);
        settle();
        write_reg(spid_pkg::CFG_GAIN_P, 16'h0100, GAIN_W);
        write_reg(spid_pkg::CFG_GAIN_I, 1, GAIN_W);
        send_word('1);
        send_word('0);
    endtask

    // Build a large integral with no gain_i clamp, then show it through gain_i
    task automatic run_saturation();
        settle();
        write_reg(spid_pkg::CFG_TORQUE_ENABLE, 1, 1);
        write_reg(spid_pkg::CFG_GOAL_POSITION, 12'hFFF, GOAL_CFG_W);
        write_reg(spid_pkg::CFG_GAIN_P, 0, GAIN_W);
        write_reg(spid_pkg::CFG_GAIN_D, 0, GAIN_W);
        write_reg(spid_pkg::CFG_TICK_PERIOD, 24'hFFFFFF, PERIOD_W);
        write_reg(spid_pkg::CFG_GAIN_I, 0, GAIN_W);
        repeat (SATURATE_WORDS) send_word(POS_W'($urandom_range(0, 7)));
        settle();
        write_reg(spid_pkg::CFG_GAIN_I, 1, GAIN_W);
        repeat (3) send_word('1);
        repeat (2) send_word('0);
    endtask

    task automatic run_random_segment(input int count);
        logic [GOAL_CFG_W-1:0] goal;
        logic [PERIOD_W-1:0]   period;
        logic [RATE_W-1:0]     rate;
        bit                    walk;
        int                    cur;
        settle();
        if ($urandom_range(0, 4) == 0)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        else
        begin
            send_idle_pct = base_send_pct;
            recv_idle_pct = base_recv_pct;
        end
        case ($urandom_range(0, 5))
            0:       goal = '0;
            1:       goal = '1;
            default: goal = GOAL_CFG_W'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 7))
            0:       period = '0;
            1:       period = 1;
            2:       period = '1;
            3:       period = PERIOD_W'($urandom_range(0, 24'hFFFFFF));
            default: period = PERIOD_W'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 7))
            0:       rate = '0;
            1:       rate = 1;
            2:       rate = '1;
            3:       rate = RATE_W'($urandom_range(0, 65535));
            default: rate = RATE_W'($urandom_range(1, 255));
        endcase
        write_reg(spid_pkg::CFG_TORQUE_ENABLE, CFG_DATA_W'($urandom_range(0, 9) != 0), 1);
        write_reg(spid_pkg::CFG_GOAL_POSITION, goal, GOAL_CFG_W);
        write_reg(spid_pkg::CFG_GAIN_P, pick_gain(1023), GAIN_W);
        write_reg(spid_pkg::CFG_GAIN_D, pick_gain(3), GAIN_W);
        write_reg(spid_pkg::CFG_TICK_PERIOD, period, PERIOD_W);
        write_reg(spid_pkg::CFG_TICK_RATE, rate, RATE_W);
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_UNMAPPED, 0, 0);
        // gain_i last: its write starts the bound divider
        if ($urandom_range(0, 2) != 0)
            write_reg(spid_pkg::CFG_GAIN_I, pick_gain(65535), GAIN_W);
        walk = ($urandom_range(0, 3) != 0);
        cur  = goal;
        repeat (count)
        begin
            if (walk && $urandom_range(0, 9) != 0)
            begin
                cur = cur + $urandom_range(0, 64) - 32;
                if (cur < 0)
                    cur = 0;
                if (cur > 4095)
                    cur = 4095;
            end
            else
                cur = $urandom_range(0, 4095);
            send_word(POS_W'(cur));
        end
    endtask

    initial
    begin
        int phase;
        int done;
        int seg;
        sb            = new();
        idle_cycles   = 0;
        words_taken   = 0;
        drives_taken  = 0;
        reg_writes    = 0;
        base_send_pct = 38;
        base_recv_pct = 87;
        send_idle_pct = base_send_pct;
        recv_idle_pct = base_recv_pct;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin base_send_pct = 38; base_recv_pct = 87; end
                1:       begin base_send_pct = 87; base_recv_pct = 38; end
                default: begin base_send_pct = 0;  base_recv_pct = 0;  end
            endcase
            send_idle_pct = base_send_pct;
            recv_idle_pct = base_recv_pct;
            if (phase == 0)
                run_directed();
            if (phase == 2)
                run_saturation();
            done = 0;
            while (done < PHASE_WORDS)
            begin
                seg = $urandom_range(16, 80);
                run_random_segment(seg);
                done = done + seg;
            end
        end
        settle();
        $display("Run took %0d position words, returned %0d drive words, made %0d register writes",
                 words_taken, drives_taken, reg_writes);
        $display("Covered torque off, integral clamp and drive limit cases under three stall regimes");
        if (sb.total_failures() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> servo_position_pid.f
+incdir+rtl
rtl/spid_pkg.sv
rtl/spid_div.sv
rtl/spid_mul.sv
rtl/spid_core.sv
rtl/servo_position_pid.sv
tb/servo_position_pid_tb.sv
